FILE: sv/fgml_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the font glyph map and locate block.
// No dependencies; used by fgml_utf8_dec and font_glyph_map_and_locate.

package fgml_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_TABLE_PRESENT   = 3'd0;
   localparam logic [2:0] CSR_GLYPH_COUNT     = 3'd1;
   localparam logic [2:0] CSR_HEADER_BYTES    = 3'd2;
   localparam logic [2:0] CSR_BYTES_PER_GLYPH = 3'd3;
   localparam logic [2:0] CSR_GLYPH_WIDTH     = 3'd4;
   localparam logic [2:0] CSR_GLYPH_HEIGHT    = 3'd5;
   localparam logic [2:0] CSR_LINE_PITCH      = 3'd6;

   localparam int unsigned CSR_DATA_W = 17;

   // Command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Table byte that steps to the next glyph
   localparam logic [7:0] GLYPH_SEP = 8'hFF;

   // Store update requested by the decoder
   typedef struct packed {
      logic        en;
      logic [15:0] code;
      logic [15:0] glyph;
   } map_type;

endpackage

FILE: sv/fgml_utf8_dec.sv
`timescale 1ns / 1ps
// UTF-8 decoder for unicode table bytes with the glyph counter.
// Depends on fgml_pkg for map_type and GLYPH_SEP.

module fgml_utf8_dec (
   input  logic             clock,
   input  logic             reset,
   input  logic             load_en,
   input  logic [7:0]       byte_in,
   output fgml_pkg::map_type map_out
);

   logic [15:0] acc_ff, acc_in;
   logic [1:0]  pend_ff, pend_in;
   logic [15:0] gcnt_ff, gcnt_in;

   // Decode one byte against the pending sequence
   always_comb begin
      acc_in        = acc_ff;
      pend_in       = pend_ff;
      gcnt_in       = gcnt_ff;
      map_out.en    = 1'b0;
      map_out.code  = 16'd0;
      map_out.glyph = gcnt_ff;
      if (pend_ff != 2'd0) begin
         acc_in  = {acc_ff[9:0], byte_in[5:0]};
         pend_in = pend_ff - 2'd1;
         if (pend_ff == 2'd1) begin
            map_out.en   = 1'b1;
            map_out.code = acc_in;
         end
      end else if (byte_in == fgml_pkg::GLYPH_SEP) begin
         gcnt_in = gcnt_ff + 16'd1;
      end else if (!byte_in[7]) begin
         map_out.en   = 1'b1;
         map_out.code = {8'd0, byte_in};
      end else if (!byte_in[5]) begin
         acc_in  = {11'd0, byte_in[4:0]};
         pend_in = 2'd1;
      end else if (!byte_in[4]) begin
         acc_in  = {12'd0, byte_in[3:0]};
         pend_in = 2'd2;
      end else if (!byte_in[3]) begin
         acc_in  = {13'd0, byte_in[2:0]};
         pend_in = 2'd3;
      end else begin
         // unrecognized lead byte maps code zero
         map_out.en   = 1'b1;
         map_out.code = 16'd0;
      end
   end

   // Advance decoder state on each load beat
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 16'd0;
         pend_ff <= 2'd0;
         gcnt_ff <= 16'd0;
      end else if (load_en) begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
         gcnt_ff <= gcnt_in;
      end
   end

endmodule

FILE: sv/font_glyph_map_and_locate.sv
`timescale 1ns / 1ps
// Font glyph map and locate: unicode table load and glyph/screen offset lookup.
// Depends on fgml_pkg and fgml_utf8_dec.
// Throughput: one beat per cycle while req_stall is low, set by the single-port
//   translation memory access. Lookups pass stages 1 to 3 and the output register;
//   a load gives no result. Reset: a clearing pass zeroes the memory with req_stall
//   high; configuration writes are taken during the pass.

module font_glyph_map_and_locate #(
   parameter int unsigned CODE_POINTS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_table_byte,
   input  logic [15:0] req_char_code,
   input  logic [9:0]  req_col,
   input  logic [8:0]  req_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_glyph_index,
   output logic [28:0] rsp_glyph_offset,
   output logic [29:0] rsp_screen_offset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [fgml_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned AW = $clog2(CODE_POINTS);
   localparam logic [AW-1:0] CLR_LAST = AW'(CODE_POINTS - 1);
   localparam logic [AW-1:0] CLR_STEP = AW'(1);
   localparam logic [16:0] CODE_LIMIT = 17'(CODE_POINTS);

   typedef enum logic [1:0] {
      PH_CLEAR = 2'b01,
      PH_RUN   = 2'b10
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   // configuration registers
   logic        tpres_ff;
   logic [16:0] gcount_ff;
   logic [15:0] header_ff;
   logic [12:0] bpg_ff;
   logic [5:0]  gwidth_ff;
   logic [5:0]  gheight_ff;
   logic [15:0] pitch_ff;

   // pipeline control
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, vo_ff, vo_in;
   logic rdy1, rdy2, rdy3, rdyo;
   logic accept, acc_load, acc_lookup;

   // memory port
   logic [15:0]   xlat_mem [0:CODE_POINTS-1];
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [15:0]   mem_wdata;
   logic [15:0]   rd_data_ff;

   fgml_pkg::map_type map;
   logic map_hit, req_hit;

   // stage registers
   logic [15:0] s1_code_ff;
   logic        s1_hit_ff;
   logic [9:0]  s1_col_ff;
   logic [8:0]  s1_row_ff;
   logic [15:0] code_sel, glyph_sel;
   logic [15:0] s2_glyph_ff;
   logic [14:0] s2_rowh_ff;
   logic [16:0] s2_colw_ff;
   logic [15:0] s3_glyph_ff;
   logic [28:0] s3_gprod_ff;
   logic [30:0] s3_rprod_ff;
   logic [16:0] s3_colw_ff;
   logic [15:0] out_glyph_ff;
   logic [28:0] out_goff_ff;
   logic [29:0] out_soff_ff;
   logic [29:0] goff_sum;
   logic [30:0] soff_sum;

   // Clearing pass sequencer
   always_comb begin
      phase_in   = phase_ff;
      clr_cnt_in = clr_cnt_ff;
      case (phase_ff)
         PH_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + CLR_STEP;
            if (clr_cnt_ff == CLR_LAST) begin
               phase_in = PH_RUN;
            end
         end
         PH_RUN: begin
            clr_cnt_in = clr_cnt_ff;
         end
         default: begin
            phase_in = PH_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tpres_ff   <= 1'b0;
         gcount_ff  <= 17'd256;
         header_ff  <= 16'd32;
         bpg_ff     <= 13'd16;
         gwidth_ff  <= 6'd8;
         gheight_ff <= 6'd16;
         pitch_ff   <= 16'd4096;
      end else if (csr_we) begin
         case (csr_index)
            fgml_pkg::CSR_TABLE_PRESENT:   tpres_ff   <= csr_wdata[0];
            fgml_pkg::CSR_GLYPH_COUNT:     gcount_ff  <= csr_wdata[16:0];
            fgml_pkg::CSR_HEADER_BYTES:    header_ff  <= csr_wdata[15:0];
            fgml_pkg::CSR_BYTES_PER_GLYPH: bpg_ff     <= csr_wdata[12:0];
            fgml_pkg::CSR_GLYPH_WIDTH:     gwidth_ff  <= csr_wdata[5:0];
            fgml_pkg::CSR_GLYPH_HEIGHT:    gheight_ff <= csr_wdata[5:0];
            fgml_pkg::CSR_LINE_PITCH:      pitch_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Stage handshake: each stage moves when the next one is free or moving
   always_comb begin
      rdyo       = !vo_ff || !rsp_stall;
      rdy3       = !v3_ff || rdyo;
      rdy2       = !v2_ff || rdy3;
      rdy1       = !v1_ff || rdy2;
      req_stall  = (phase_ff != PH_RUN) || !rdy1;
      accept     = req_valid && !req_stall;
      acc_load   = accept && (req_cmd == fgml_pkg::CMD_LOAD);
      acc_lookup = accept && (req_cmd == fgml_pkg::CMD_LOOKUP);
      v1_in      = acc_lookup || (v1_ff && !rdy2);
      v2_in      = (v1_ff && rdy2) || (v2_ff && !rdy3);
      v3_in      = (v2_ff && rdy3) || (v3_ff && !rdyo);
      vo_in      = (v3_ff && rdyo) || (vo_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   fgml_utf8_dec u_dec (
      .clock   (clock),
      .reset   (reset),
      .load_en (acc_load),
      .byte_in (req_table_byte),
      .map_out (map)
   );

   // Steer the single memory port: clear, load write or lookup read
   always_comb begin
      map_hit   = {1'b0, map.code} < CODE_LIMIT;
      req_hit   = {1'b0, req_char_code} < CODE_LIMIT;
      mem_we    = 1'b0;
      mem_waddr = map.code[AW-1:0];
      mem_wdata = map.glyph;
      if (phase_ff == PH_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = 16'd0;
      end else if (acc_load && map.en && map_hit) begin
         mem_we = 1'b1;
      end
      mem_re    = acc_lookup && req_hit;
      mem_raddr = req_char_code[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         xlat_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= xlat_mem[mem_raddr];
      end
   end

   // Stage 1: capture the lookup beat while the memory read is in flight
   always_ff @(posedge clock) begin
      if (acc_lookup) begin
         s1_code_ff <= req_char_code;
         s1_hit_ff  <= req_hit;
         s1_col_ff  <= req_col;
         s1_row_ff  <= req_row;
      end
   end

   // Translate and clamp to a valid glyph
   always_comb begin
      code_sel = s1_code_ff;
      if (tpres_ff) begin
         code_sel = s1_hit_ff ? rd_data_ff : 16'd0;
      end
      glyph_sel = ((code_sel != 16'd0) && ({1'b0, code_sel} < gcount_ff)) ? code_sel : 16'd0;
   end

   // Stage 2: glyph and the narrow cell products
   always_ff @(posedge clock) begin
      if (v1_ff && rdy2) begin
         s2_glyph_ff <= glyph_sel;
         s2_rowh_ff  <= {6'd0, s1_row_ff} * {9'd0, gheight_ff};
         s2_colw_ff  <= {7'd0, s1_col_ff} * {10'd0, ({1'b0, gwidth_ff} + 7'd1)};
      end
   end

   // Stage 3: wide products
   always_ff @(posedge clock) begin
      if (v2_ff && rdy3) begin
         s3_glyph_ff <= s2_glyph_ff;
         s3_gprod_ff <= {13'd0, s2_glyph_ff} * {16'd0, bpg_ff};
         s3_rprod_ff <= {16'd0, s2_rowh_ff} * {15'd0, pitch_ff};
         s3_colw_ff  <= s2_colw_ff;
      end
   end

   // Output stage: final sums wrapped to the field widths
   always_comb begin
      goff_sum = {1'b0, s3_gprod_ff} + {14'd0, header_ff};
      soff_sum = s3_rprod_ff + {12'd0, s3_colw_ff, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (v3_ff && rdyo) begin
         out_glyph_ff <= s3_glyph_ff;
         out_goff_ff  <= goff_sum[28:0];
         out_soff_ff  <= soff_sum[29:0];
      end
   end

   assign rsp_valid         = vo_ff;
   assign rsp_glyph_index   = out_glyph_ff;
   assign rsp_glyph_offset  = out_goff_ff;
   assign rsp_screen_offset = out_soff_ff;

`ifndef SYNTHESIS
   // the single port never sees a read and a write together
   a_port_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("translation memory read and write in one cycle");

   // no lookup is in flight while the store is being cleared
   a_clear_empty : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CLEAR) |-> (!v1_ff && !v2_ff && !v3_ff && !vo_ff))
      else $error("lookup in flight during clearing pass");

   // the clearing pass steps one entry each cycle until it ends
   a_clear_step : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CLEAR) |=> ((phase_ff == PH_RUN) ||
                                  (clr_cnt_ff == $past(clr_cnt_ff) + CLR_STEP)))
      else $error("clearing pass skipped an entry");

   // stage 3 keeps its beat while the output stage is full and stalled
   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      (v3_ff && vo_ff && rsp_stall) |=> (v3_ff && $stable(s3_gprod_ff)))
      else $error("stage 3 beat lost under output stall");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for font_glyph_map_and_locate: UTF-8 table loads and glyph lookups.
// Needs fgml_pkg and the block's RTL; a scoreboard class predicts every lookup result.

module testbench;
   import fgml_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 262144;  // clearing pass plus plenty of slack
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned PHASE_BEATS    = 320;
   localparam int unsigned NUM_PHASES     = 6;
   localparam int unsigned MAX_REPORTS    = 100;

   localparam logic [2:0] CSR_SPARE  = 3'd7;   // unused index, must be ignored
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;
   localparam logic [7:0] UTF8_BAD   = 8'hF8;

   typedef struct packed {
      logic [15:0] glyph;
      logic [28:0] glyph_off;
      logic [29:0] screen_off;
   } cell_loc_t;

   typedef struct {
      bit        tbl_on;
      bit [16:0] n_glyphs;
      bit [15:0] hdr_bytes;
      bit [12:0] glyph_bytes;
      bit [5:0]  cell_w;
      bit [5:0]  cell_h;
      bit [15:0] pitch;
   } font_setup_t;

   // Predicts glyph and offsets for each lookup and holds them until the result beat shows up
   class glyph_locate_scoreboard;
      bit [15:0]   xlat_store [65536];
      bit [15:0]   glyph_ctr;
      bit [15:0]   code_acc;
      bit [1:0]    cont_left;
      bit          tbl_on;
      bit [16:0]   n_glyphs;
      bit [15:0]   hdr_bytes;
      bit [12:0]   glyph_bytes;
      bit [5:0]    cell_w;
      bit [5:0]    cell_h;
      bit [15:0]   pitch;
      cell_loc_t   loc_queue [$];
      int unsigned errors;
      int unsigned results_checked;
      int unsigned bytes_loaded;
      int unsigned lookups_seen;

      function new();
         tbl_on      = 1'b0;
         n_glyphs    = 17'd256;
         hdr_bytes   = 16'd32;
         glyph_bytes = 13'd16;
         cell_w      = 6'd8;
         cell_h      = 6'd16;
         pitch       = 16'd4096;
      endfunction

      function int unsigned pending();
         return loc_queue.size();
      endfunction

      function void write_reg(logic [2:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_TABLE_PRESENT:   tbl_on      = val[0];
            CSR_GLYPH_COUNT:     n_glyphs    = val[16:0];
            CSR_HEADER_BYTES:    hdr_bytes   = val[15:0];
            CSR_BYTES_PER_GLYPH: glyph_bytes = val[12:0];
            CSR_GLYPH_WIDTH:     cell_w      = val[5:0];
            CSR_GLYPH_HEIGHT:    cell_h      = val[5:0];
            CSR_LINE_PITCH:      pitch       = val[15:0];
            default: ;
         endcase
      endfunction

      // One table byte: separator, ASCII, lead of a multi-byte run, or continuation
      function void decode_table_byte(bit [7:0] b);
         if (cont_left != 0) begin
            code_acc = {code_acc[9:0], b[5:0]};
            cont_left--;
            if (cont_left == 0) xlat_store[code_acc] = glyph_ctr;
         end else if (b == GLYPH_SEP) begin
            glyph_ctr++;
         end else if (!b[7]) begin
            xlat_store[{8'd0, b}] = glyph_ctr;
         end else if (!b[5]) begin
            code_acc  = {11'd0, b[4:0]};
            cont_left = 2'd1;
         end else if (!b[4]) begin
            code_acc  = {12'd0, b[3:0]};
            cont_left = 2'd2;
         end else if (!b[3]) begin
            code_acc  = {13'd0, b[2:0]};
            cont_left = 2'd3;
         end else begin
            // unknown lead maps code zero
            xlat_store[0] = glyph_ctr;
         end
      endfunction

      function void take_request(logic cmd, logic [7:0] tbyte, logic [15:0] code,
                                 logic [9:0] col, logic [8:0] row);
         bit [15:0]       c;
         bit [15:0]       g;
         longint unsigned goff;
         longint unsigned soff;
         cell_loc_t       loc;
         if (cmd == CMD_LOAD) begin
            bytes_loaded++;
            decode_table_byte(tbyte);
            return;
         end
         lookups_seen++;
         c = code;
         if (tbl_on) c = xlat_store[c];
         g = (c != 0 && {1'b0, c} < n_glyphs) ? c : 16'd0;
         goff = 64'(hdr_bytes) + 64'(g) * 64'(glyph_bytes);
         soff = 64'(row) * 64'(cell_h) * 64'(pitch) + 64'(col) * (64'(cell_w) + 64'd1) * 64'd4;
         loc.glyph      = g;
         loc.glyph_off  = goff[28:0];
         loc.screen_off = soff[29:0];
         loc_queue.push_back(loc);
      endfunction

      function void compare_field(string fname, logic [29:0] want, logic [29:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
         end
      endfunction

      function void check_location(logic [15:0] g, logic [28:0] goff, logic [29:0] soff);
         cell_loc_t want;
         if (loc_queue.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result beat with nothing outstanding, expected none actual %0d/%0d/%0d",
                        $time, g, goff, soff);
            return;
         end
         want = loc_queue.pop_front();
         results_checked++;
         compare_field("glyph_index", 30'(want.glyph), 30'(g));
         compare_field("glyph_offset", 30'(want.glyph_off), 30'(goff));
         compare_field("screen_offset", want.screen_off, soff);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = CMD_LOAD;
   logic [7:0]  req_table_byte = 8'd0;
   logic [15:0] req_char_code = 16'd0;
   logic [9:0]  req_col = 10'd0;
   logic [8:0]  req_row = 9'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_glyph_index;
   logic [28:0] rsp_glyph_offset;
   logic [29:0] rsp_screen_offset;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   glyph_locate_scoreboard sb;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_tag = 0;
   int unsigned hold_ack = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned beats_sent = 0;
   int unsigned setups_used = 0;
   bit [15:0]   recent_codes [$];

   font_glyph_map_and_locate dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_table_byte    (req_table_byte),
      .req_char_code     (req_char_code),
      .req_col           (req_col),
      .req_row           (req_row),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_glyph_index   (rsp_glyph_index),
      .rsp_glyph_offset  (rsp_glyph_offset),
      .rsp_screen_offset (rsp_screen_offset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: random stall, or a long hold-off when the main flow asks for one
   always @(posedge clock) begin
      if (hold_ack != hold_tag) begin
         hold_ack  = hold_tag;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Monitor both channels; count cycles in which no beat moves
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall === 1'b0)
         sb.take_request(req_cmd, req_table_byte, req_char_code, req_col, req_row);
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_location(rsp_glyph_index, rsp_glyph_offset, rsp_screen_offset);
      if (!reset && ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int unsigned pick_edge(int unsigned maxv);
      int unsigned k;
      k = $urandom_range(9);
      if (k == 0) return 0;
      if (k == 1) return maxv;
      return $urandom_range(maxv);
   endfunction

   function automatic font_setup_t make_setup(bit tp, bit [16:0] gc, bit [15:0] hb,
                                              bit [12:0] bpg, bit [5:0] gw, bit [5:0] gh,
                                              bit [15:0] lp);
      font_setup_t s;
      s.tbl_on = tp; s.n_glyphs = gc; s.hdr_bytes = hb; s.glyph_bytes = bpg;
      s.cell_w = gw; s.cell_h = gh; s.pitch = lp;
      return s;
   endfunction

   // Register write; leaves csr_we high for back-to-back writes, and the caller drops it after the last one
   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic apply_setup(input font_setup_t s);
      csr_write(CSR_TABLE_PRESENT, CSR_DATA_W'(s.tbl_on));
      csr_write(CSR_GLYPH_COUNT, CSR_DATA_W'(s.n_glyphs));
      csr_write(CSR_HEADER_BYTES, CSR_DATA_W'(s.hdr_bytes));
      csr_write(CSR_BYTES_PER_GLYPH, CSR_DATA_W'(s.glyph_bytes));
      csr_write(CSR_GLYPH_WIDTH, CSR_DATA_W'(s.cell_w));
      csr_write(CSR_GLYPH_HEIGHT, CSR_DATA_W'(s.cell_h));
      csr_write(CSR_LINE_PITCH, CSR_DATA_W'(s.pitch));
      csr_we <= 1'b0;
      setups_used++;
   endtask

   // Offer one beat, with random idle cycles ahead of it, and hold it until taken
   task automatic send_beat(input logic cmd, input logic [7:0] tbyte, input logic [15:0] code,
                            input logic [9:0] col, input logic [8:0] row);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_table_byte <= tbyte;
      req_char_code  <= code;
      req_col        <= col;
      req_row        <= row;
      do @(posedge clock); while (req_stall !== 1'b0);
      beats_sent++;
   endtask

   task automatic send_load(input logic [7:0] b);
      send_beat(CMD_LOAD, b, 16'($urandom), 10'($urandom), 9'($urandom));
   endtask

   task automatic send_lookup(input logic [15:0] code, input logic [9:0] col,
                              input logic [8:0] row);
      send_beat(CMD_LOOKUP, 8'($urandom), code, col, row);
   endtask

   // Encode a code point in n bytes; the block keeps only the low 16 bits
   task automatic send_utf8(input bit [20:0] cp, input int unsigned n);
      case (n)
         1: send_load({1'b0, cp[6:0]});
         2: begin
            send_load(UTF8_LEAD2 | 8'(cp[10:6]));
            send_load(UTF8_CONT | 8'(cp[5:0]));
         end
         3: begin
            send_load(UTF8_LEAD3 | 8'(cp[15:12]));
            send_load(UTF8_CONT | 8'(cp[11:6]));
            send_load(UTF8_CONT | 8'(cp[5:0]));
         end
         default: begin
            send_load(UTF8_LEAD4 | 8'(cp[20:18]));
            send_load(UTF8_CONT | 8'(cp[17:12]));
            send_load(UTF8_CONT | 8'(cp[11:6]));
            send_load(UTF8_CONT | 8'(cp[5:0]));
         end
      endcase
      recent_codes.push_back(cp[15:0]);
      if (recent_codes.size() > 64) void'(recent_codes.pop_front());
   endtask

   // One random unit of traffic: mostly well-formed table entries and lookups
   task automatic random_unit();
      int unsigned pick;
      int unsigned n;
      bit [20:0]   cp;
      bit [15:0]   code;
      pick = $urandom_range(99);
      if (pick < 35) begin
         if ($urandom_range(99) < 45 && recent_codes.size() > 0)
            code = recent_codes[$urandom_range(recent_codes.size() - 1)];
         else
            code = 16'(pick_edge(16'hFFFF));
         send_lookup(code, 10'(pick_edge(1023)), 9'(pick_edge(511)));
      end else if (pick < 45) begin
         send_load(GLYPH_SEP);
      end else if (pick < 87) begin
         n = $urandom_range(1, 4);
         case (n)
            1: cp = 21'($urandom_range(127));
            2: cp = 21'($urandom_range(2047));
            3: cp = 21'($urandom_range(16'hFFFF));
            default: cp = 21'($urandom);
         endcase
         send_utf8(cp, n);
      end else begin
         case ($urandom_range(2))
            0: repeat ($urandom_range(1, 3)) send_load(8'($urandom));
            1: begin
               // truncated run: the next lead gets swallowed as a continuation
               send_load(UTF8_LEAD3 | 8'($urandom_range(15)));
               send_utf8(21'($urandom_range(2047)), 2);
            end
            default: send_load(UTF8_BAD | 8'($urandom_range(6)));
         endcase
      end
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned goal;
      goal = beats_sent + count;
      while (beats_sent < goal) random_unit();
   endtask

   // Wait out every outstanding lookup, then let in-flight loads settle
   task automatic wait_drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic directed_part();
      bit [7:0] seq [$];
      seq = '{8'h41, GLYPH_SEP, 8'hC3, 8'hA9, GLYPH_SEP, 8'hE2, 8'h82, 8'hAC, GLYPH_SEP,
              8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF8, 8'h85, GLYPH_SEP, 8'hA1, 8'h80, 8'h81};
      // lookup into the freshly cleared store
      send_lookup(16'h0041, 10'd0, 9'd0);
      // ASCII, 2/3/4-byte runs, bad lead, separator as continuation, stray continuation leads
      foreach (seq[i]) send_load(seq[i]);
      send_lookup(16'h00E9, 10'd1023, 9'd511);
      send_lookup(16'h20AC, 10'd512, 9'd256);
      send_lookup(16'hF600, 10'd1, 9'd1);
      send_lookup(16'h0000, 10'd0, 9'd511);
      send_lookup(16'hFFFF, 10'd1023, 9'd0);
      send_lookup(16'h017F, 10'd7, 9'd3);
   endtask

   initial begin
      font_setup_t plan [NUM_PHASES];
      int unsigned idle_plan [NUM_PHASES];
      int unsigned stall_plan [NUM_PHASES];
      sb = new();

      plan[0] = make_setup(1'b1, 17'd65536, 16'hFFFF, 13'd4096, 6'd32, 6'd32, 16'hFFFF);
      plan[1] = make_setup(1'b0, 17'd0, 16'd0, 13'd1, 6'd1, 6'd1, 16'd0);
      plan[2] = make_setup(1'b1, 17'd1, 16'd100, 13'h1FFF, 6'd63, 6'd0, 16'hFFFF);
      plan[3] = make_setup(1'b1, 17'h1FFFF, 16'd12345, 13'd0, 6'd0, 6'd63, 16'd8000);
      for (int p = 4; p < NUM_PHASES; p++)
         plan[p] = make_setup(1'($urandom), 17'($urandom_range(65536)), 16'($urandom),
                              13'($urandom_range(1, 4096)), 6'($urandom_range(1, 32)),
                              6'($urandom_range(1, 32)), 16'($urandom));
      idle_plan  = '{0, 54, 0, 7, 0, 54};
      stall_plan = '{0, 0, 54, 7, 0, 7};

      // Hold reset, then set up the font while the store clears
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      csr_write(CSR_SPARE, '1);
      apply_setup(make_setup(1'b1, 17'd256, 16'd32, 13'd16, 6'd8, 6'd16, 16'd4096));

      directed_part();
      req_valid <= 1'b0;
      wait_drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         apply_setup(plan[p]);
         idle_pct  = idle_plan[p];
         stall_pct = stall_plan[p];
         if (p == 4) hold_tag++;   // back up the result side while the sender keeps going
         run_random(PHASE_BEATS / 2);
         if (p == 0) begin
            // sender pauses until every lookup has come back
            req_valid <= 1'b0;
            wait_drain();
         end
         run_random(PHASE_BEATS / 2);
         req_valid <= 1'b0;
         wait_drain();
      end

      $display("Drove %0d table bytes and %0d lookups over %0d font setups; %0d checked,",
               sb.bytes_loaded, sb.lookups_seen, setups_used, sb.results_checked);
      $display("  with idle, stall and hold-off phases and %0d glyph separators seen.",
               sb.glyph_ctr);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/fgml_pkg.sv
sv/fgml_utf8_dec.sv
sv/font_glyph_map_and_locate.sv
verif/testbench.sv
